/* design/mpd_pkg.sv */
`timescale 1ns / 1ps
package mpd_pkg;

  // Packet geometry
  localparam int FIELD_COUNT = 14;
  localparam int PKT_LEN     = 3 * FIELD_COUNT + 3;
  localparam logic [7:0] PKT_LEN_B = 8'(PKT_LEN);
  localparam logic [7:0] SYNC_RESET = 8'hAA;

  // Widths
  localparam int FIDX_W  = 5;
  localparam int VALUE_W = 24;
  localparam int PADDR_W = ($clog2(FIELD_COUNT) > 0) ? $clog2(FIELD_COUNT) : 1;
  localparam logic [PADDR_W-1:0] LAST_FIELD = PADDR_W'(FIELD_COUNT - 1);

  // Output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  // Status codes
  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  // Byte selector inside one field
  localparam logic [1:0] SEL_LO  = 2'd0;
  localparam logic [1:0] SEL_MID = 2'd1;
  localparam logic [1:0] SEL_HI  = 2'd2;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_LEN,
    ST_DATA,
    ST_CSUM
  } front_state_t;

  // Payload write port, front to back
  typedef struct packed {
    logic               en;
    logic [PADDR_W-1:0] addr;
    logic [VALUE_W-1:0] data;
  } pwr_t;

  // Packet command, front to back
  typedef struct packed {
    logic push;
    logic bad;
  } cmd_t;

  // One result word
  typedef struct packed {
    logic [FIDX_W-1:0]         field_index;
    logic signed [VALUE_W-1:0] field_value;
    logic                      status;
    logic                      last;
  } result_t;

endpackage

/* design/mpd_front.sv */
`timescale 1ns / 1ps
module mpd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [7:0]          in_rx_byte,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_sync_byte,
  input  logic                busy_i,
  output mpd_pkg::pwr_t       pwr_o,
  output mpd_pkg::cmd_t       cmd_o
);
  import mpd_pkg::*;

  front_state_t       state_r, state_nxt;
  logic [7:0]         sync_r;
  logic [7:0]         sum_r, sum_nxt;
  logic [1:0]         sel_r, sel_nxt;
  logic [PADDR_W-1:0] widx_r, widx_nxt;
  logic [7:0]         lo_r, lo_nxt;
  logic [7:0]         mid_r, mid_nxt;
  logic               acc;

  assign cfg_ready = 1'b1;
  assign acc = in_push & ~in_full;

  // Hold off data and checksum bytes while the previous packet still reads the payload store
  assign in_full = busy_i & ((state_r == ST_DATA) | (state_r == ST_CSUM));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_HUNT: if (acc && in_rx_byte == sync_r) state_nxt = ST_LEN;
      ST_LEN: if (acc) begin
        state_nxt = (in_rx_byte == PKT_LEN_B) ? ST_DATA : ST_HUNT;
      end
      ST_DATA: if (acc && sel_r == SEL_HI && widx_r == LAST_FIELD) state_nxt = ST_CSUM;
      ST_CSUM: if (acc) state_nxt = ST_HUNT;
      default: state_nxt = ST_HUNT;
    endcase
  end

  // Sum and byte assembly
  always_comb begin
    sum_nxt  = sum_r;
    sel_nxt  = sel_r;
    widx_nxt = widx_r;
    lo_nxt   = lo_r;
    mid_nxt  = mid_r;
    unique case (state_r)
      ST_HUNT: if (acc) sum_nxt = in_rx_byte;
      ST_LEN: if (acc) begin
        sum_nxt  = sum_r + in_rx_byte;
        sel_nxt  = SEL_LO;
        widx_nxt = '0;
      end
      ST_DATA: if (acc) begin
        sum_nxt = sum_r + in_rx_byte;
        case (sel_r)
          SEL_LO:  begin lo_nxt = in_rx_byte;  sel_nxt = SEL_MID; end
          SEL_MID: begin mid_nxt = in_rx_byte; sel_nxt = SEL_HI;  end
          default: begin
            sel_nxt = SEL_LO;
            if (widx_r != LAST_FIELD) widx_nxt = widx_r + 1'b1;
          end
        endcase
      end
      ST_CSUM: if (acc) sum_nxt = '0;
      default: sum_nxt = sum_r;
    endcase
  end

  // Outputs to the back end
  always_comb begin
    pwr_o      = '0;
    cmd_o      = '0;
    pwr_o.addr = widx_r;
    pwr_o.data = {in_rx_byte, mid_r, lo_r};
    cmd_o.bad  = (sum_r + in_rx_byte) != 8'd0;
    unique case (state_r)
      ST_DATA: pwr_o.en = acc & (sel_r == SEL_HI);
      ST_CSUM: cmd_o.push = acc;
      default: begin
        pwr_o.en   = 1'b0;
        cmd_o.push = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      sync_r  <= SYNC_RESET;
      sum_r   <= '0;
      sel_r   <= SEL_LO;
      widx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      sel_r   <= sel_nxt;
      widx_r  <= widx_nxt;
      if (cfg_valid && cfg_ready) sync_r <= cfg_sync_byte;
    end
  end

  // Partial field bytes
  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    mid_r <= mid_nxt;
  end

endmodule

/* design/mpd_back.sv */
`timescale 1ns / 1ps
module mpd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mpd_pkg::pwr_t        pwr_i,
  input  mpd_pkg::cmd_t        cmd_i,
  output logic                 busy_o,
  input  logic [mpd_pkg::OQ_CW-1:0] oq_count_i,
  output logic                 res_push_o,
  output mpd_pkg::result_t     res_o
);
  import mpd_pkg::*;

  // Payload store, one 24-bit word per field
  logic [VALUE_W-1:0] mem [FIELD_COUNT];
  logic [VALUE_W-1:0] rdata_r;

  // Command queue, two entries
  logic       cq_bad_r [2];
  logic       cq_wp_r, cq_rp_r;
  logic [1:0] cq_cnt_r, cq_cnt_nxt;
  logic       cq_pop;

  // Sequencer
  logic [PADDR_W-1:0] fidx_r, fidx_nxt;
  logic               issue;
  logic               head_bad;
  logic               issue_last;

  // Read stage
  logic               s1_vld_r;
  logic [PADDR_W-1:0] s1_idx_r;
  logic               s1_bad_r;
  logic               s1_last_r;

  assign busy_o   = cq_cnt_r != 2'd0;
  assign head_bad = cq_bad_r[cq_rp_r];

  // Issue a read only while the output queue has room for it
  assign issue = busy_o &
                 ((OQ_CW'(oq_count_i) + OQ_CW'(s1_vld_r)) < OQ_CW'(OQ_DEPTH));
  assign issue_last = head_bad | (fidx_r == LAST_FIELD);
  assign cq_pop     = issue & issue_last;

  always_comb begin
    fidx_nxt = fidx_r;
    if (issue) fidx_nxt = issue_last ? '0 : fidx_r + 1'b1;
  end

  always_comb begin
    cq_cnt_nxt = cq_cnt_r;
    case ({cmd_i.push, cq_pop})
      2'b10:   cq_cnt_nxt = cq_cnt_r + 1'b1;
      2'b01:   cq_cnt_nxt = cq_cnt_r - 1'b1;
      default: cq_cnt_nxt = cq_cnt_r;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cq_wp_r  <= 1'b0;
      cq_rp_r  <= 1'b0;
      cq_cnt_r <= '0;
      fidx_r   <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      cq_cnt_r <= cq_cnt_nxt;
      fidx_r   <= fidx_nxt;
      s1_vld_r <= issue;
      if (cmd_i.push) cq_wp_r <= ~cq_wp_r;
      if (cq_pop)     cq_rp_r <= ~cq_rp_r;
    end
  end

  // Command payload and read stage
  always_ff @(posedge clk) begin
    if (cmd_i.push) cq_bad_r[cq_wp_r] <= cmd_i.bad;
    s1_idx_r  <= fidx_r;
    s1_bad_r  <= head_bad;
    s1_last_r <= issue_last;
  end

  // Payload memory
  always_ff @(posedge clk) begin
    if (pwr_i.en) mem[pwr_i.addr] <= pwr_i.data;
    rdata_r <= mem[fidx_r];
  end

  // Result word
  always_comb begin
    res_push_o        = s1_vld_r;
    res_o.field_index = s1_bad_r ? '0 : FIDX_W'(s1_idx_r);
    res_o.field_value = s1_bad_r ? '0 : $signed(rdata_r);
    res_o.status      = s1_bad_r ? STATUS_BAD : STATUS_GOOD;
    res_o.last        = s1_last_r;
  end

endmodule

/* design/mpd_outq.sv */
`timescale 1ns / 1ps
module mpd_outq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push_i,
  input  mpd_pkg::result_t          res_i,
  input  logic                      out_pop,
  output logic                      out_empty,
  output mpd_pkg::result_t          res_o,
  output logic [mpd_pkg::OQ_CW-1:0] count_o
);
  import mpd_pkg::*;

  result_t           q_r [OQ_DEPTH];
  logic [OQ_AW-1:0]  wp_r, rp_r;
  logic [OQ_CW-1:0]  cnt_r, cnt_nxt;
  logic              pop;

  assign out_empty = cnt_r == '0;
  assign pop       = out_pop & ~out_empty;
  assign res_o     = q_r[rp_r];
  assign count_o   = cnt_r;

  // Occupancy; the back end never pushes into a full queue
  always_comb begin
    cnt_nxt = cnt_r;
    case ({push_i, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_i) wp_r <= wp_r + 1'b1;
      if (pop)    rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) q_r[wp_r] <= res_i;
  end

endmodule

/* design/meter_packet_deframer_core.sv */
`timescale 1ns / 1ps
// Channel | Handshake            | Word
// --------+----------------------+-------------------------------------------
// in      | in_push / in_full    | in_rx_byte[7:0]
// out     | out_pop / out_empty  | out_field_index, out_field_value, out_status,
//         |                      | out_last
// cfg     | cfg_valid / cfg_ready| cfg_sync_byte[7:0] (ready always high)
//
// One byte is taken per cycle, but data bytes of the next packet stall
// (in_full) until the previous packet has left the payload store. A good
// packet drains as FIELD_COUNT words, one per cycle while the four-word output
// queue has room, through a one-read-port payload store; a bad checksum gives
// one word. Reset is synchronous, active low, and clears all control state.
module meter_packet_deframer_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic [7:0]                            in_rx_byte,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic [mpd_pkg::FIDX_W-1:0]            out_field_index,
  output logic signed [mpd_pkg::VALUE_W-1:0]    out_field_value,
  output logic                                  out_status,
  output logic                                  out_last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [7:0]                            cfg_sync_byte
);
  import mpd_pkg::*;

  pwr_t             pwr;
  cmd_t             cmd;
  logic             busy;
  logic [OQ_CW-1:0] oq_count;
  logic             res_push;
  result_t          res_in;
  result_t          res_out;

  mpd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_rx_byte   (in_rx_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_sync_byte(cfg_sync_byte),
    .busy_i       (busy),
    .pwr_o        (pwr),
    .cmd_o        (cmd)
  );

  mpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pwr_i     (pwr),
    .cmd_i     (cmd),
    .busy_o    (busy),
    .oq_count_i(oq_count),
    .res_push_o(res_push),
    .res_o     (res_in)
  );

  mpd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (res_push),
    .res_i    (res_in),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .res_o    (res_out),
    .count_o  (oq_count)
  );

  assign out_field_index = res_out.field_index;
  assign out_field_value = res_out.field_value;
  assign out_status      = res_out.status;
  assign out_last        = res_out.last;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import mpd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 16;
  localparam int LONG_HOLD    = 400;
  localparam int SPLIT_AT     = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_push = 1'b0;
  logic                       in_full;
  logic [7:0]                 in_rx_byte = 8'h00;
  logic                       out_empty;
  logic                       out_pop = 1'b0;
  logic [FIDX_W-1:0]          out_field_index;
  logic signed [VALUE_W-1:0]  out_field_value;
  logic                       out_status;
  logic                       out_last;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [7:0]                 cfg_sync_byte = 8'h00;

  meter_packet_deframer_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_rx_byte      (in_rx_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_field_index (out_field_index),
    .out_field_value (out_field_value),
    .out_status      (out_status),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_sync_byte   (cfg_sync_byte)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Bytes waiting to be sent and words waiting to be received
  logic [7:0] rx_backlog[$];
  result_t    expected_words[$];
  int         planned_bytes = 0;
  int         mismatch_count = 0;
  int         words_seen = 0;
  int         hold_requests = 0;
  bit         no_idle = 1'b0;

  // Deframer tracking state
  logic [7:0] track_sync = SYNC_RESET;
  int         track_pos = 0;
  logic [7:0] track_sum = 8'h00;
  logic [7:0] track_data[3*FIELD_COUNT];

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  // Advance the tracked deframer by one accepted byte
  task automatic deframe_byte(input logic [7:0] b);
    result_t    w;
    logic [7:0] total;
    if (track_pos == 0) begin
      if (b == track_sync) begin
        track_sum = b;
        track_pos = 1;
      end
    end else if (track_pos == 1) begin
      // a bad length byte is dropped, not rechecked as sync
      if (b == PKT_LEN_B) begin
        track_sum = track_sum + b;
        track_pos = 2;
      end else begin
        track_pos = 0;
      end
    end else if (track_pos < PKT_LEN - 1) begin
      track_data[track_pos-2] = b;
      track_sum = track_sum + b;
      track_pos++;
    end else begin
      total = track_sum + b;
      if (total == 8'h00) begin
        for (int i = 0; i < FIELD_COUNT; i++) begin
          w.field_index = FIDX_W'(i);
          w.field_value = {track_data[3*i+2], track_data[3*i+1], track_data[3*i]};
          w.status      = STATUS_GOOD;
          w.last        = (i == FIELD_COUNT - 1);
          expected_words.push_back(w);
        end
      end else begin
        w.field_index = '0;
        w.field_value = '0;
        w.status      = STATUS_BAD;
        w.last        = 1'b1;
        expected_words.push_back(w);
      end
      track_pos = 0;
      track_sum = 8'h00;
    end
  endtask

  // Byte sender: holds push until accepted, random idle bursts
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push  <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_push && !in_full) deframe_byte(in_rx_byte);
      if (in_push && in_full) begin
        // keep offering the same byte
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_push  <= 1'b0;
      end else if (rx_backlog.size() == 0) begin
        in_push <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 4);
        in_push  <= 1'b0;
      end else begin
        in_push    <= 1'b1;
        in_rx_byte <= rx_backlog.pop_front();
      end
    end
  end

  int pop_gap = 0;
  int hold_left = 0;
  int holds_served = 0;

  // Long receiver hold, counted down in cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Word receiver and checker
  always @(posedge clk) begin
    result_t w;
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_gap <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          note_mismatch($sformatf("word %0d: unexpected, idx %0d value %h status %0b last %0b",
                                  words_seen, out_field_index, out_field_value,
                                  out_status, out_last));
        end else begin
          w = expected_words.pop_front();
          if (out_field_index !== w.field_index || out_field_value !== w.field_value ||
              out_status !== w.status || out_last !== w.last)
            note_mismatch($sformatf({"word %0d: expected idx %0d value %h status %0b last %0b,",
                                     " got idx %0d value %h status %0b last %0b"},
                                    words_seen, w.field_index, w.field_value, w.status,
                                    w.last, out_field_index, out_field_value,
                                    out_status, out_last));
        end
      end
      if (hold_left > 0) begin
        out_pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        out_pop <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        pop_gap <= $urandom_range(0, 4);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Watchdog
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    rx_backlog.push_back(b);
    planned_bytes++;
  endtask

  // Field value: mostly random, often a corner value; only corner values when corners is set
  function automatic logic [23:0] pick_field(input logic [7:0] sync_val, input int k,
                                             input bit corners);
    logic [23:0] corner_list[7];
    corner_list = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000001,
                    24'hFFFFFE, {3{sync_val}}};
    if (corners) return corner_list[k % 7];
    if ($urandom_range(0, 3) == 0) return corner_list[$urandom_range(0, 6)];
    return 24'($urandom);
  endfunction

  // Build a full packet; a bad one carries a corrupted checksum
  task automatic build_packet(output logic [7:0] pkt[$], input logic [7:0] sync_val,
                              input bit good, input bit corners);
    logic [7:0]  sum;
    logic [7:0]  csum;
    logic [23:0] v;
    pkt = {};
    pkt.push_back(sync_val);
    pkt.push_back(PKT_LEN_B);
    sum = sync_val + PKT_LEN_B;
    for (int f = 0; f < FIELD_COUNT; f++) begin
      v = pick_field(sync_val, f, corners);
      pkt.push_back(v[7:0]);
      pkt.push_back(v[15:8]);
      pkt.push_back(v[23:16]);
      sum = sum + v[7:0] + v[15:8] + v[23:16];
    end
    csum = ~sum + 8'd1;
    if (!good) csum = csum ^ 8'($urandom_range(1, 255));
    pkt.push_back(csum);
  endtask

  // Mostly well-formed packets, some noise, bad lengths and bad checksums
  task automatic random_traffic(input logic [7:0] sync_val, input int upto);
    logic [7:0] pkt[$];
    logic [7:0] b;
    int         pick;
    while (planned_bytes < upto) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (pick == 1) begin
        b = 8'($urandom);
        if (b == PKT_LEN_B) b = ~b;
        send_byte(sync_val);
        send_byte(b);
      end else begin
        build_packet(pkt, sync_val, pick > 2, 1'b0);
        foreach (pkt[k]) send_byte(pkt[k]);
      end
    end
  endtask

  // Wait until every byte is in and every word is out, then let the block settle
  task automatic wait_idle();
    do @(negedge clk);
    while (rx_backlog.size() != 0 || in_push || expected_words.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_sync(input logic [7:0] v);
    @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_sync_byte <= v;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    track_sync = v;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stimulus sequence
  initial begin
    logic [7:0] pkt[$];
    logic [7:0] gen_sync;

    gen_sync = SYNC_RESET;

    // Directed: noise, bad lengths (sync as length, off by one), corner packets, good and bad
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(gen_sync);
    send_byte(gen_sync);
    send_byte(PKT_LEN_B);
    send_byte(gen_sync);
    send_byte(PKT_LEN_B - 8'd1);
    send_byte(gen_sync);
    send_byte(PKT_LEN_B + 8'd1);
    build_packet(pkt, gen_sync, 1'b1, 1'b1);
    foreach (pkt[k]) send_byte(pkt[k]);
    build_packet(pkt, gen_sync, 1'b0, 1'b1);
    foreach (pkt[k]) send_byte(pkt[k]);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // Lowest sync value
    gen_sync = 8'h00;
    write_sync(gen_sync);
    random_traffic(gen_sync, 140);
    wait_idle();

    // Highest sync value; receiver stalls long enough to back up the input
    gen_sync = 8'hFF;
    write_sync(gen_sync);
    hold_requests++;
    repeat (2) begin
      build_packet(pkt, gen_sync, 1'b1, 1'b0);
      foreach (pkt[k]) send_byte(pkt[k]);
    end
    // stop partway through a packet and change sync underneath it
    build_packet(pkt, gen_sync, 1'b1, 1'b0);
    for (int k = 0; k < SPLIT_AT; k++) send_byte(pkt[k]);
    wait_idle();

    // Sync equal to the length byte; old packet finishes with its original sum
    gen_sync = PKT_LEN_B;
    write_sync(gen_sync);
    for (int k = SPLIT_AT; k < pkt.size(); k++) send_byte(pkt[k]);
    random_traffic(gen_sync, 270);
    wait_idle();

    // Random sync, no idling on either side
    gen_sync = 8'($urandom);
    write_sync(gen_sync);
    no_idle = 1'b1;
    random_traffic(gen_sync, 300);
    wait_idle();

    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
